// ----- src/cof_pkg.sv -----
// shared types, widths and constants for the current offset calibration block
`default_nettype none

package cof_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS       = 16;
  localparam int OFFSET_LIMIT_BITS = 15;
  localparam int SETTLE_BITS       = 8;
  localparam int BAD_BITS          = 3;
  localparam int CFG_INDEX_BITS    = 2;
  localparam int CFG_DATA_BITS     = 15;

  // default window length as a power of two
  localparam int WINDOW_LOG2_DEFAULT = 5;

  // register reset values
  localparam logic [SETTLE_BITS-1:0]       SETTLE_LIMIT_RESET = 8'd200;
  localparam logic [OFFSET_LIMIT_BITS-1:0] OFFSET_LIMIT_RESET = 15'd5120;
  localparam logic [BAD_BITS-1:0]          BAD_LIMIT_RESET    = 3'd5;
  localparam logic [BAD_BITS-1:0]          BAD_COUNT_MAX      = 3'd7;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_SETTLE_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFFSET_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BAD_LIMIT    = 2'd2;

  // most negative sample value and its clamped replacement
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN =
    {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN_CLAMP =
    {1'b1, {(SAMPLE_BITS-2){1'b0}}, 1'b1};

  // input request payload
  typedef struct packed {
    logic                          idle;
    logic signed [SAMPLE_BITS-1:0] u_sample;
    logic signed [SAMPLE_BITS-1:0] v_sample;
  } cof_in_t;

  // result payload
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] u_offset;
    logic signed [SAMPLE_BITS-1:0] v_offset;
    logic                          run_enable;
    logic                          check_error;
  } cof_out_t;

  // configuration register set
  typedef struct packed {
    logic [SETTLE_BITS-1:0]       settle_limit;
    logic [OFFSET_LIMIT_BITS-1:0] offset_limit;
    logic [BAD_BITS-1:0]          bad_limit;
  } cof_cfg_t;

  // per-lane commands from the sequencer
  typedef struct packed {
    logic clear;
    logic accumulate;
    logic done;
  } cof_lane_ctrl_t;

  // what a lane found for the current window
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] avg;
    logic                          in_range;
  } cof_lane_res_t;

endpackage

`default_nettype wire

// ----- src/cof_lane.sv -----
// one channel lane: window accumulator, floor average, clamp and limit check
`default_nettype none

module cof_lane #(
  parameter int WINDOW_LOG2 = cof_pkg::WINDOW_LOG2_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic signed [cof_pkg::SAMPLE_BITS-1:0] sample,
  input  wire logic [cof_pkg::OFFSET_LIMIT_BITS-1:0]  offset_limit,
  input  wire cof_pkg::cof_lane_ctrl_t                ctrl,
  output cof_pkg::cof_lane_res_t                      res
);
  import cof_pkg::*;

  localparam int SUM_BITS = SAMPLE_BITS + WINDOW_LOG2;

  logic signed [SUM_BITS-1:0]    sum;
  logic signed [SUM_BITS-1:0]    sum_acc;
  logic signed [SUM_BITS-1:0]    avg_full;
  logic signed [SAMPLE_BITS-1:0] avg_raw;
  logic signed [SAMPLE_BITS-1:0] avg;
  logic signed [SAMPLE_BITS:0]   avg_ext;
  logic signed [SAMPLE_BITS:0]   lim_ext;
  logic signed [SAMPLE_BITS:0]   lim_neg;

  // running sum including this sample
  assign sum_acc  = sum + SUM_BITS'(sample);

  // floor average by arithmetic shift, most negative value raised by one
  assign avg_full = sum_acc >>> WINDOW_LOG2;
  assign avg_raw  = avg_full[SAMPLE_BITS-1:0];
  assign avg      = (avg_raw == SAMPLE_MIN) ? SAMPLE_MIN_CLAMP : avg_raw;

  // strict check of the absolute average against the limit
  assign avg_ext  = {avg[SAMPLE_BITS-1], avg};
  assign lim_ext  = {{(SAMPLE_BITS+1-OFFSET_LIMIT_BITS){1'b0}}, offset_limit};
  assign lim_neg  = -lim_ext;

  assign res.avg      = avg;
  assign res.in_range = (avg_ext < lim_ext) && (avg_ext > lim_neg);

  // accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
    end else if (ctrl.clear) begin
      sum <= '0;
    end else if (ctrl.accumulate) begin
      sum <= ctrl.done ? '0 : sum_acc;
    end
  end

endmodule

`default_nettype wire

// ----- src/cof_ctrl.sv -----
// settle and window sequencer, merge of lane results and sticky flags
`default_nettype none

module cof_ctrl #(
  parameter int WINDOW_LOG2 = cof_pkg::WINDOW_LOG2_DEFAULT
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    fire,
  input  wire logic                    idle,
  input  wire cof_pkg::cof_cfg_t       cfg,
  input  wire cof_pkg::cof_lane_res_t  lane_u,
  input  wire cof_pkg::cof_lane_res_t  lane_v,
  output cof_pkg::cof_lane_ctrl_t      lane_ctrl,
  output cof_pkg::cof_out_t            result
);
  import cof_pkg::*;

  logic [SETTLE_BITS-1:0]        settle_count;
  logic [SETTLE_BITS-1:0]        settle_count_next;
  logic [WINDOW_LOG2-1:0]        window_count;
  logic [WINDOW_LOG2-1:0]        window_count_next;
  logic signed [SAMPLE_BITS-1:0] offset_u;
  logic signed [SAMPLE_BITS-1:0] offset_u_next;
  logic signed [SAMPLE_BITS-1:0] offset_v;
  logic signed [SAMPLE_BITS-1:0] offset_v_next;
  logic [BAD_BITS-1:0]           bad_count;
  logic [BAD_BITS-1:0]           bad_count_next;
  logic                          enable_flag;
  logic                          enable_flag_next;
  logic                          error_flag;
  logic                          error_flag_next;

  logic [SETTLE_BITS:0]   settle_inc;
  logic [SETTLE_BITS-1:0] settle_sat;
  logic                   settling;
  logic                   averaging;
  logic                   window_done;
  logic                   window_ok;

  // saturating settle count and phase decode
  assign settle_inc  = {1'b0, settle_count} + {{SETTLE_BITS{1'b0}}, 1'b1};
  assign settle_sat  = (settle_inc > {1'b0, cfg.settle_limit}) ?
                       cfg.settle_limit : settle_inc[SETTLE_BITS-1:0];
  assign settling    = idle && (settle_sat < cfg.settle_limit);
  assign averaging   = idle && !(settle_sat < cfg.settle_limit);
  assign window_done = averaging && (window_count == {WINDOW_LOG2{1'b1}});
  assign window_ok   = lane_u.in_range && lane_v.in_range;

  // lane commands; clear and accumulate are qualified by an accepted request
  assign lane_ctrl.clear      = fire && settling;
  assign lane_ctrl.accumulate = fire && averaging;
  assign lane_ctrl.done       = window_done;

  // next state
  always_comb begin
    settle_count_next = settle_count;
    window_count_next = window_count;
    offset_u_next     = offset_u;
    offset_v_next     = offset_v;
    bad_count_next    = bad_count;
    enable_flag_next  = enable_flag;
    error_flag_next   = error_flag;
    if (!idle) begin
      settle_count_next = '0;
    end else begin
      settle_count_next = settle_sat;
      if (settling) begin
        window_count_next = '0;
      end else if (window_done) begin
        window_count_next = '0;
        enable_flag_next  = 1'b1;
        if (window_ok) begin
          offset_u_next  = lane_u.avg;
          offset_v_next  = lane_v.avg;
          bad_count_next = '0;
        end else begin
          if (bad_count < BAD_COUNT_MAX) begin
            bad_count_next = bad_count + {{(BAD_BITS-1){1'b0}}, 1'b1};
          end
          if (bad_count > cfg.bad_limit) begin
            error_flag_next   = 1'b1;
            bad_count_next    = '0;
            settle_count_next = '0;
          end
        end
      end else begin
        window_count_next = window_count + {{(WINDOW_LOG2-1){1'b0}}, 1'b1};
      end
    end
  end

  // result shows the state after this request
  assign result.u_offset    = offset_u_next;
  assign result.v_offset    = offset_v_next;
  assign result.run_enable  = enable_flag_next;
  assign result.check_error = error_flag_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_count <= '0;
      window_count <= '0;
      offset_u     <= '0;
      offset_v     <= '0;
      bad_count    <= '0;
      enable_flag  <= 1'b0;
      error_flag   <= 1'b0;
    end else if (fire) begin
      settle_count <= settle_count_next;
      window_count <= window_count_next;
      offset_u     <= offset_u_next;
      offset_v     <= offset_v_next;
      bad_count    <= bad_count_next;
      enable_flag  <= enable_flag_next;
      error_flag   <= error_flag_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/cof_skid.sv -----
// output register with skid stage that takes one more request under a stall
`default_nettype none

module cof_skid (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire cof_pkg::cof_out_t push_data,
  output logic                   can_push,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cof_pkg::cof_out_t      out_data
);
  import cof_pkg::*;

  logic     main_valid;
  logic     skid_valid;
  cof_out_t main_data;
  cof_out_t skid_data;
  logic     main_free;

  assign main_free = !main_valid || out_ready;
  assign can_push  = !skid_valid;
  assign out_valid = main_valid;
  assign out_data  = main_data;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      main_valid <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (main_free) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- src/current_offset_calibration_top.sv -----
// Current sensor offset calibration, top level.
// Input channel in_valid/in_ready/in_data carries one request per ADC
// conversion: idle flag plus signed U and V phase samples. Every accepted
// request yields exactly one result on out_valid/out_ready/out_data with
// the accepted U and V offsets and the sticky run_enable and check_error
// flags as they stand after that request.
// Configuration writes come on cfg_valid/cfg_ready with cfg_index and
// cfg_data (settle limit, offset limit, bad window limit); cfg_ready is
// always high and unknown indexes are dropped.
// Throughput: one request per cycle while in_ready is high. The U and V
// lanes and the merge sequencer settle the whole update of a request
// combinationally, the settle counter feeding back into the next request.
// The result is registered in the main register of the output stage.
// Reset clears all state, loads the register defaults and empties the
// output stage. When the receiver stalls, one more result is held in the
// skid stage, after which in_ready drops until the stalled result is taken.
`default_nettype none

module current_offset_calibration_top #(
  parameter int WINDOW_LOG2 = cof_pkg::WINDOW_LOG2_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire cof_pkg::cof_in_t                     in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output cof_pkg::cof_out_t                         out_data,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [cof_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [cof_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import cof_pkg::*;

  cof_cfg_t       cfg;
  cof_lane_ctrl_t lane_ctrl;
  cof_lane_res_t  lane_u;
  cof_lane_res_t  lane_v;
  cof_out_t       result;
  logic           fire;

  assign cfg_ready = 1'b1;
  assign fire      = in_valid && in_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_limit <= SETTLE_LIMIT_RESET;
      cfg.offset_limit <= OFFSET_LIMIT_RESET;
      cfg.bad_limit    <= BAD_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SETTLE_LIMIT: cfg.settle_limit <= cfg_data[SETTLE_BITS-1:0];
        REG_OFFSET_LIMIT: cfg.offset_limit <= cfg_data[OFFSET_LIMIT_BITS-1:0];
        REG_BAD_LIMIT:    cfg.bad_limit    <= cfg_data[BAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // U channel lane
  cof_lane #(.WINDOW_LOG2(WINDOW_LOG2)) u_lane_u (
    .clk          (clk),
    .rst          (rst),
    .sample       (in_data.u_sample),
    .offset_limit (cfg.offset_limit),
    .ctrl         (lane_ctrl),
    .res          (lane_u)
  );

  // V channel lane
  cof_lane #(.WINDOW_LOG2(WINDOW_LOG2)) u_lane_v (
    .clk          (clk),
    .rst          (rst),
    .sample       (in_data.v_sample),
    .offset_limit (cfg.offset_limit),
    .ctrl         (lane_ctrl),
    .res          (lane_v)
  );

  // sequencer and merge
  cof_ctrl #(.WINDOW_LOG2(WINDOW_LOG2)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .idle      (in_data.idle),
    .cfg       (cfg),
    .lane_u    (lane_u),
    .lane_v    (lane_v),
    .lane_ctrl (lane_ctrl),
    .result    (result)
  );

  // output stage
  cof_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (fire),
    .push_data (result),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- src/cof_checker.sv -----
// port-level checks for the current offset calibration block, bound to the top
`default_nettype none

module cof_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire cof_pkg::cof_out_t out_data
);
  import cof_pkg::*;

  logic seen_run;
  logic seen_err;

  // remember sticky flags already delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_run <= 1'b0;
      seen_err <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_run <= seen_run || out_data.run_enable;
      seen_err <= seen_err || out_data.check_error;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // output stage empty after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  // run enable never drops once delivered
  a_run_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_run |-> out_data.run_enable)
    else $error("run_enable dropped");

  // check error never drops once delivered
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen_err |-> out_data.check_error)
    else $error("check_error dropped");

  // offsets never carry the most negative code
  a_no_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.u_offset != SAMPLE_MIN) && (out_data.v_offset != SAMPLE_MIN))
    else $error("offset not clamped");

endmodule

bind current_offset_calibration_top cof_checker u_cof_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
